/* rtl/modular_exponentiation_top_defines.svh */
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define MEXP_NEVER(lbl, clk, rst_n, expr, msg) \
  `MEXP_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word types, sequencer states and default widths.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned FieldW   = 32;
  localparam int unsigned WidthDef = 32;

  typedef struct packed {
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] exponent;
    logic [FieldW-1:0] modulus;
  } mexp_in_t;

  typedef struct packed {
    logic [FieldW-1:0] power;
    logic              bad_modulus;
  } mexp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EBIT,
    ST_MDBL,
    ST_MADD
  } mexp_state_e;

endpackage

/* rtl/modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply over a shared double-and-add modular unit.
//
//   channel   handshake        word        direction
//   input     start / busy     item_i      in
//   result    done_o strobe    result_o    out
//
// Zero modulus: result strobe in the cycle after the word is taken.
// Otherwise the base is first reduced mod the modulus, then each exponent bit up
// to the highest set one costs a multiply when set, then a square of the base;
// each modular product doubles once per multiplier bit, MSB first, and adds
// once per set multiplier bit, all on the shared modular adder.
// Reset clears the sequencer; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = mexp_pkg::WidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mexp_pkg::mexp_in_t  item_i,
  output logic                done_o,
  output mexp_pkg::mexp_out_t result_o
);

  localparam int unsigned CntW   = $clog2(WIDTH);
  localparam int unsigned FieldW = mexp_pkg::FieldW;

  mexp_pkg::mexp_state_e state_q, state_d;

  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic             sq_q, sq_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  mexp_pkg::mexp_out_t res_q, res_d;

  logic [WIDTH-1:0] mod_in;
  logic [WIDTH-1:0] x_op;
  logic [WIDTH-1:0] unit_c;
  logic             unit_cin;
  logic [WIDTH-1:0] unit_s;
  logic             accept;
  logic             last;
  logic             step_end;

  assign accept   = start && !busy;
  assign mod_in   = WIDTH'(item_i.modulus);
  assign last     = (cnt_q == '0);
  assign x_op     = sq_q ? base_q : acc_q;
  assign unit_c   = (state_q == mexp_pkg::ST_MADD) ? x_op : r_q;
  assign unit_cin = (state_q == mexp_pkg::ST_REDUCE) && base_q[WIDTH-1];
  assign step_end = (state_q == mexp_pkg::ST_MADD) ||
                    ((state_q == mexp_pkg::ST_MDBL) && !y_q[WIDTH-1]);

  mexp_modadd #(
    .WIDTH (WIDTH)
  ) u_modadd (
    .a_i   (r_q),
    .c_i   (unit_c),
    .cin_i (unit_cin),
    .m_i   (mod_q),
    .s_o   (unit_s)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (accept && (mod_in != '0)) state_d = mexp_pkg::ST_REDUCE;
      end
      mexp_pkg::ST_REDUCE: begin
        if (last) state_d = mexp_pkg::ST_EBIT;
      end
      mexp_pkg::ST_EBIT: begin
        state_d = (exp_q == '0) ? mexp_pkg::ST_IDLE : mexp_pkg::ST_MDBL;
      end
      mexp_pkg::ST_MDBL: begin
        if (y_q[WIDTH-1])      state_d = mexp_pkg::ST_MADD;
        else if (last && sq_q) state_d = mexp_pkg::ST_EBIT;
      end
      mexp_pkg::ST_MADD: begin
        state_d = (last && sq_q) ? mexp_pkg::ST_EBIT : mexp_pkg::ST_MDBL;
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    base_d = base_q;
    exp_d  = exp_q;
    mod_d  = mod_q;
    acc_d  = acc_q;
    r_d    = r_q;
    y_d    = y_q;
    sq_d   = sq_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    res_d  = res_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (accept) begin
          base_d = WIDTH'(item_i.base);
          exp_d  = WIDTH'(item_i.exponent);
          mod_d  = mod_in;
          acc_d  = WIDTH'(1);
          r_d    = '0;
          cnt_d  = CntW'(WIDTH - 1);
          if (mod_in == '0) begin
            done_d            = 1'b1;
            res_d.power       = '0;
            res_d.bad_modulus = 1'b1;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        // shift base bits into the remainder, MSB first
        r_d    = unit_s;
        base_d = base_q << 1;
        cnt_d  = cnt_q - CntW'(1);
        if (last) base_d = unit_s;
      end
      mexp_pkg::ST_EBIT: begin
        if (exp_q == '0) begin
          done_d            = 1'b1;
          res_d.power       = FieldW'(acc_q);
          res_d.bad_modulus = 1'b0;
        end else begin
          sq_d  = !exp_q[0];
          r_d   = '0;
          y_d   = base_q;
          cnt_d = CntW'(WIDTH - 1);
        end
      end
      mexp_pkg::ST_MDBL,
      mexp_pkg::ST_MADD: begin
        r_d = unit_s;
        if (step_end) begin
          y_d   = y_q << 1;
          cnt_d = cnt_q - CntW'(1);
          if (last) begin
            if (sq_q) begin
              base_d = unit_s;
              exp_d  = exp_q >> 1;
            end else begin
              // multiply done; square the base next
              acc_d = unit_s;
              sq_d  = 1'b1;
              r_d   = '0;
              y_d   = base_q;
              cnt_d = CntW'(WIDTH - 1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    y_q    <= y_d;
    sq_q   <= sq_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != mexp_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* rtl/mexp_modadd.sv */
// ----------------------------------------------------------------------------
// Modular adder
// Computes (a + c + cin) mod m for a, c below m; one conditional subtract.
// ----------------------------------------------------------------------------
module mexp_modadd #(
  parameter int unsigned WIDTH = mexp_pkg::WidthDef
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] c_i,
  input  logic             cin_i,
  input  logic [WIDTH-1:0] m_i,
  output logic [WIDTH-1:0] s_o
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] diff;

  assign sum  = {1'b0, a_i} + {1'b0, c_i} + {{WIDTH{1'b0}}, cin_i};
  assign diff = sum - {1'b0, m_i};

  // sum stays below 2m, so one subtract brings it into range
  assign s_o = (sum >= {1'b0, m_i}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

/* rtl/mexp_checker.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_top_defines.svh"

module mexp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input mexp_pkg::mexp_in_t  item_i,
  input logic                done_o,
  input mexp_pkg::mexp_out_t result_o
);

  `MEXP_ASSERT(a_zero_mod_flag, clk_i, rst_ni, (start && !busy && item_i.modulus == '0) |=> (done_o && result_o.bad_modulus), "zero modulus word not flagged next cycle")
  `MEXP_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy, "result strobe while busy")
  `MEXP_NEVER(a_bad_power_zero, clk_i, rst_ni, done_o && result_o.bad_modulus && (result_o.power != '0), "flagged result has nonzero power")
  `MEXP_ASSERT(a_busy_end_done, clk_i, rst_ni, $fell(busy) |-> done_o, "busy dropped without a result")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

/* verif/tb_modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Feeds base/exponent/modulus words through the start/busy handshake, predicts
// each power in the testbench and checks every strobed result in order.
// Directed corner words come first, then random words under several idle mixes.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top;

  localparam int unsigned WIDTH     = mexp_pkg::WidthDef;
  localparam int unsigned RAND_WORDS = 268;
  localparam int unsigned DRAIN     = 4 * WIDTH * WIDTH + 2 * WIDTH + 64;
  localparam longint     CYCLE_MAX = 8000000;
  localparam int unsigned MAX_SHOWN = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  mexp_pkg::mexp_in_t  item_i;
  logic                done_o;
  mexp_pkg::mexp_out_t result_o;

  mexp_pkg::mexp_in_t  pending_words[$];
  mexp_pkg::mexp_out_t expected_powers[$];

  logic      word_taken;
  longint    cycles;
  int        taken_cnt;
  int        checked_cnt;
  int        mismatches;
  int        zero_mod_cnt;
  int        zero_exp_cnt;

  modular_exponentiation_top #(
    .WIDTH(WIDTH)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // (x + y) mod m for x, y below m
  function automatic logic [63:0] add_reduce(logic [63:0] x, logic [63:0] y,
                                             logic [63:0] m);
    logic [63:0] s;
    s = x + y;
    if (s < x || s >= m) s = s - m;
    return s;
  endfunction

  // double-and-add modular product, multiplier bits from the top down
  function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y,
                                             logic [63:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      r = add_reduce(r, r, m);
      if (y[i]) r = add_reduce(r, x, m);
    end
    return r;
  endfunction

  function automatic mexp_pkg::mexp_out_t predict_power(mexp_pkg::mexp_in_t w);
    logic [63:0]         mask;
    logic [63:0]         b;
    logic [63:0]         e;
    logic [63:0]         m;
    logic [63:0]         acc;
    mexp_pkg::mexp_out_t r;
    mask = {64{1'b1}} >> (64 - WIDTH);
    b    = 64'(w.base) & mask;
    e    = 64'(w.exponent) & mask;
    m    = 64'(w.modulus) & mask;
    r    = '0;
    if (m == 0) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    b   = b % m;
    acc = 64'd1;
    for (int i = 0; i < WIDTH; i++) begin
      if (e[i]) acc = mul_reduce(acc % m, b, m);
      b = mul_reduce(b, b, m);
    end
    r.power = acc[mexp_pkg::FieldW-1:0];
    return r;
  endfunction

  // idle mix rotates every 40 words: none, heavy, none, light
  function automatic int unsigned idle_pct(int n);
    case ((n / 40) % 4)
      1:       return 65;
      3:       return 18;
      default: return 0;
    endcase
  endfunction

  task automatic queue_word(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    mexp_pkg::mexp_in_t w;
    w.base     = b;
    w.exponent = e;
    w.modulus  = m;
    if (m == 0) zero_mod_cnt++;
    if (e == 0) zero_exp_cnt++;
    pending_words.push_back(w);
  endtask

  // Driver: hold the word until taken, then present the next one or idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(taken_cnt)) begin
          start  <= 1'b1;
          item_i <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check strobed results, then record any word taken at this edge.
  always @(posedge clk_i) begin
    word_taken = 1'b0;
    if (rst_ni) begin
      cycles++;
      if (done_o) begin
        if (expected_powers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result at cycle %0d: power %h bad_modulus %b",
                     cycles, result_o.power, result_o.bad_modulus);
        end else begin
          mexp_pkg::mexp_out_t exp_r;
          exp_r = expected_powers.pop_front();
          checked_cnt++;
          if (result_o.power !== exp_r.power ||
              result_o.bad_modulus !== exp_r.bad_modulus) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch at cycle %0d: power exp %h got %h, bad_modulus exp %b got %b",
                       cycles, exp_r.power, result_o.power,
                       exp_r.bad_modulus, result_o.bad_modulus);
          end
        end
      end
      word_taken = start && !busy;
      if (word_taken) begin
        expected_powers.push_back(predict_power(item_i));
        taken_cnt++;
      end
      if (cycles > CYCLE_MAX) begin
        $display("timeout after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] b;
    logic [31:0] e;
    logic [31:0] m;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    word_taken   = 1'b0;
    cycles       = 0;
    taken_cnt    = 0;
    checked_cnt  = 0;
    mismatches   = 0;
    zero_mod_cnt = 0;
    zero_exp_cnt = 0;

    // directed corners
    queue_word(32'h0, 32'h0, 32'h0);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_word(32'h1234_5678, 32'h0, 32'h0);
    queue_word(32'h0, 32'h0, 32'h1);
    queue_word(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    queue_word(32'h5, 32'h3, 32'h1);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
    queue_word(32'h0, 32'h5, 32'h7);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    queue_word(32'h2, 32'hA, 32'd1000);
    queue_word(32'h3, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_word(32'hFFFF_FFFF, 32'h7, 32'd13);
    queue_word(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    queue_word(32'hFFFF_FFFE, 32'h1, 32'hFFFF_FFFF);
    queue_word(32'h7, 32'h8000_0000, 32'hFFFF_FFF1);
    queue_word(32'h8000_0000, 32'h2, 32'h8000_0001);
    queue_word(32'hFFFF_FFFA, 32'h2, 32'hFFFF_FFFB);
    queue_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCD);
    queue_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
    queue_word(32'h3, 32'h1, 32'h2);
    queue_word(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h2);

    for (int n = 0; n < RAND_WORDS; n++) begin
      case ($urandom_range(19))
        0:       m = 32'h0;
        1, 2:    m = $urandom_range(16, 1);
        3, 4, 5, 6, 7, 8: m = $urandom | 32'h8000_0000;
        default: m = $urandom;
      endcase
      case ($urandom_range(9))
        0:       e = $urandom_range(1);
        1, 2, 3: e = $urandom_range(255);
        4:       e = $urandom | 32'hF000_0000;
        default: e = $urandom;
      endcase
      case ($urandom_range(9))
        0:       b = 32'h0;
        1:       b = 32'hFFFF_FFFF;
        2:       b = m - 32'h1;
        3:       b = m * $urandom_range(3);
        default: b = $urandom;
      endcase
      queue_word(b, e, m);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || start || expected_powers.size() != 0)
      @(posedge clk_i);
    // hold to catch any stray strobe
    repeat (DRAIN) @(posedge clk_i);

    $display("Checked %0d results from %0d words in %0d cycles", checked_cnt, taken_cnt,
             cycles);
    $display("Covered %0d zero-modulus and %0d zero-exponent words, %0d mismatches",
             zero_mod_cnt, zero_exp_cnt, mismatches);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
